// ----- rtl/asfg_pkg.sv -----
package asfg_pkg;

  localparam int DelayDepth = 64;
  localparam int MaxOut     = 64;
  localparam int HoldCap    = (DelayDepth < MaxOut) ? DelayDepth : MaxOut;
  localparam int AddrW      = $clog2(DelayDepth);
  localparam int CntW       = $clog2(DelayDepth + 1);
  localparam int RunW       = 7;
  localparam int CalcW      = (CntW > RunW) ? CntW : RunW;
  localparam int DataW      = 16;
  localparam int ThrW       = 15;
  localparam int LenW       = 6;
  localparam int CfgIdxW    = 2;

  localparam logic [RunW-1:0] RunSat = 7'd127;

  localparam logic [ThrW-1:0] ThrReset     = 15'd33;
  localparam logic [LenW-1:0] MinRunReset  = 6'd32;
  localparam logic [LenW-1:0] MinFragReset = 6'd32;

  typedef enum logic [CfgIdxW-1:0] {
    CfgThreshold = 2'd0,
    CfgMinRun    = 2'd1,
    CfgMinFrag   = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StEval,
    StPlan,
    StClear,
    StRead,
    StLoad
  } state_e;

  typedef struct packed {
    logic [ThrW-1:0] thr;
    logic [LenW-1:0] min_run;
    logic [LenW-1:0] min_frag;
  } cfg_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [DataW-1:0] wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

  // ring slot of the k-th held sample counted from base
  function automatic logic [AddrW-1:0] slot(input logic [AddrW-1:0] base,
                                            input logic [CntW-1:0]  k);
    logic [AddrW:0] sum;
    sum = {1'b0, base} + (AddrW + 1)'(k);
    if (sum >= (AddrW + 1)'(DelayDepth)) begin
      sum = sum - (AddrW + 1)'(DelayDepth);
    end
    return sum[AddrW-1:0];
  endfunction

endpackage

// ----- rtl/asfg_ram.sv -----
module asfg_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- rtl/asfg_ctrl.sv -----
module asfg_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  asfg_pkg::cfg_t                  cfg_i,
  input  logic                            in_valid_i,
  input  logic signed [asfg_pkg::DataW-1:0] sample_i,
  input  logic                            last_i,
  input  logic                            out_free_i,
  output logic                            in_ready_o,
  output asfg_pkg::mem_req_t              mem_o,
  output logic                            out_load_o,
  output logic                            out_last_o
);

  asfg_pkg::state_e state_q, state_d;

  logic [asfg_pkg::AddrW-1:0] head_q, head_d;
  logic [asfg_pkg::CntW-1:0]  fill_q, fill_d;
  logic [asfg_pkg::RunW-1:0]  run_q, run_d;
  logic [asfg_pkg::RunW-1:0]  frag_q, frag_d;
  logic                       silent_q, silent_d;
  logic                       last_q, last_d;
  logic                       clr_q, clr_d;
  logic                       one_q, one_d;
  logic [asfg_pkg::CntW-1:0]  count_q, count_d;
  logic [asfg_pkg::CntW-1:0]  k_q, k_d;
  logic [asfg_pkg::CntW-1:0]  emit_q, emit_d;
  logic                       olast_q, olast_d;

  logic                       accept;
  logic [asfg_pkg::DataW-1:0] mag;
  logic                       silent_c;

  logic [asfg_pkg::RunW-1:0]  min_run_w, min_frag_w;
  logic [asfg_pkg::RunW-1:0]  run_inc;
  logic                       over_p, over_n;
  logic [asfg_pkg::RunW:0]    frag_sum;
  logic [asfg_pkg::RunW-1:0]  frag_sat;

  logic [asfg_pkg::CalcW-1:0] run_w, fill_w, frag_w;
  logic [asfg_pkg::CalcW-1:0] n_w, rest_w, m_w, zc_w;
  logic [asfg_pkg::RunW-1:0]  pend;
  logic [asfg_pkg::CalcW-1:0] pend_w, keep_w, keep2_w, ex_w;
  logic                       frag_short;

  assign accept = in_valid_i && (state_q == asfg_pkg::StIdle);

  // magnitude of Q15; -32768 maps to 32768
  assign mag      = sample_i[asfg_pkg::DataW-1] ? (~sample_i + 16'd1) : sample_i;
  assign silent_c = mag < {1'b0, cfg_i.thr};

  assign min_run_w  = {1'b0, cfg_i.min_run};
  assign min_frag_w = {1'b0, cfg_i.min_frag};

  // run and fragment update
  assign run_inc  = (run_q == asfg_pkg::RunSat) ? asfg_pkg::RunSat : run_q + 7'd1;
  assign over_p   = run_q > min_run_w;
  assign over_n   = run_inc > min_run_w;
  assign frag_sum = {1'b0, frag_q} + {1'b0, run_q} + 8'd1;
  assign frag_sat = (frag_sum > {1'b0, asfg_pkg::RunSat}) ? asfg_pkg::RunSat
                                                          : frag_sum[asfg_pkg::RunW-1:0];

  // clear span and release count, from the updated run and fragment
  assign run_w      = asfg_pkg::CalcW'(run_q);
  assign fill_w     = asfg_pkg::CalcW'(fill_q);
  assign frag_w     = asfg_pkg::CalcW'(frag_q);
  assign frag_short = frag_q < min_frag_w;
  assign n_w        = (run_w < fill_w) ? run_w : fill_w;
  assign rest_w     = fill_w - n_w;
  assign m_w        = ((frag_q != '0) && frag_short) ? ((frag_w < rest_w) ? frag_w : rest_w)
                                                     : '0;
  assign zc_w       = clr_q ? (n_w + m_w) : (one_q ? asfg_pkg::CalcW'(1) : '0);

  assign pend    = (run_q <= min_run_w) ? (run_q + (frag_short ? frag_q : '0)) : '0;
  assign pend_w  = asfg_pkg::CalcW'(pend);
  assign keep_w  = (pend_w < asfg_pkg::CalcW'(asfg_pkg::HoldCap - 1)) ? pend_w
                 : asfg_pkg::CalcW'(asfg_pkg::HoldCap - 1);
  assign keep2_w = (keep_w < fill_w) ? keep_w : fill_w;
  assign ex_w    = last_q ? fill_w : (fill_w - keep2_w);

  always_comb begin
    state_d = state_q;
    case (state_q)
      asfg_pkg::StIdle: begin
        if (accept) begin
          state_d = asfg_pkg::StEval;
        end
      end
      asfg_pkg::StEval: begin
        state_d = asfg_pkg::StPlan;
      end
      asfg_pkg::StPlan: begin
        if (zc_w != '0) begin
          state_d = asfg_pkg::StClear;
        end else if (ex_w != '0) begin
          state_d = asfg_pkg::StRead;
        end else begin
          state_d = asfg_pkg::StIdle;
        end
      end
      asfg_pkg::StClear: begin
        if (count_q == asfg_pkg::CntW'(1)) begin
          state_d = (emit_q != '0) ? asfg_pkg::StRead : asfg_pkg::StIdle;
        end
      end
      asfg_pkg::StRead: begin
        if (out_free_i) begin
          state_d = asfg_pkg::StLoad;
        end
      end
      asfg_pkg::StLoad: begin
        state_d = (emit_q == '0) ? asfg_pkg::StIdle : asfg_pkg::StRead;
      end
      default: begin
        state_d = asfg_pkg::StIdle;
      end
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    mem_o      = '0;
    case (state_q)
      asfg_pkg::StIdle: begin
        in_ready_o  = 1'b1;
        mem_o.we    = accept;
        mem_o.waddr = asfg_pkg::slot(head_q, fill_q);
        mem_o.wdata = sample_i;
      end
      asfg_pkg::StClear: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = asfg_pkg::slot(head_q, k_q);
        mem_o.wdata = '0;
      end
      asfg_pkg::StRead: begin
        mem_o.re    = out_free_i;
        mem_o.raddr = head_q;
      end
      asfg_pkg::StLoad: begin
        out_load_o = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  assign out_last_o = olast_q;

  always_comb begin
    head_d   = head_q;
    fill_d   = fill_q;
    run_d    = run_q;
    frag_d   = frag_q;
    silent_d = silent_q;
    last_d   = last_q;
    clr_d    = clr_q;
    one_d    = one_q;
    count_d  = count_q;
    k_d      = k_q;
    emit_d   = emit_q;
    olast_d  = olast_q;
    case (state_q)
      asfg_pkg::StIdle: begin
        if (accept) begin
          fill_d   = fill_q + asfg_pkg::CntW'(1);
          silent_d = silent_c;
          last_d   = last_i;
        end
      end
      asfg_pkg::StEval: begin
        if (silent_q) begin
          run_d = run_inc;
          clr_d = (over_n && !over_p) || (last_q && !over_n);
          one_d = over_n && over_p;
        end else begin
          run_d  = '0;
          frag_d = over_p ? 7'd1 : frag_sat;
          clr_d  = 1'b0;
          one_d  = 1'b0;
        end
      end
      asfg_pkg::StPlan: begin
        count_d = zc_w[asfg_pkg::CntW-1:0];
        k_d     = fill_q - zc_w[asfg_pkg::CntW-1:0];
        emit_d  = ex_w[asfg_pkg::CntW-1:0];
        if (last_q) begin
          run_d  = '0;
          frag_d = '0;
        end
      end
      asfg_pkg::StClear: begin
        k_d     = k_q + asfg_pkg::CntW'(1);
        count_d = count_q - asfg_pkg::CntW'(1);
      end
      asfg_pkg::StRead: begin
        if (out_free_i) begin
          head_d  = asfg_pkg::slot(head_q, asfg_pkg::CntW'(1));
          fill_d  = fill_q - asfg_pkg::CntW'(1);
          emit_d  = emit_q - asfg_pkg::CntW'(1);
          olast_d = last_q && (fill_q == asfg_pkg::CntW'(1));
        end
      end
      asfg_pkg::StLoad: begin
        // end of clip: ring restarts at slot zero
        if ((emit_q == '0) && last_q) begin
          head_d = '0;
        end
      end
      default: begin
        head_d = head_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= asfg_pkg::StIdle;
      head_q   <= '0;
      fill_q   <= '0;
      run_q    <= '0;
      frag_q   <= '0;
      silent_q <= 1'b0;
      last_q   <= 1'b0;
      clr_q    <= 1'b0;
      one_q    <= 1'b0;
      count_q  <= '0;
      k_q      <= '0;
      emit_q   <= '0;
      olast_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      fill_q   <= fill_d;
      run_q    <= run_d;
      frag_q   <= frag_d;
      silent_q <= silent_d;
      last_q   <= last_d;
      clr_q    <= clr_d;
      one_q    <= one_d;
      count_q  <= count_d;
      k_q      <= k_d;
      emit_q   <= emit_d;
      olast_q  <= olast_d;
    end
  end

endmodule

// ----- rtl/audio_silence_fragment_gate_core.sv -----
// Channel  Direction  Handshake               Payload
// cfg      in         cfg_we_i                cfg_idx_i, cfg_data_i
// in       in         in_valid_i/in_ready_o   sample_in_i, last_in_i
// out      out        out_valid_o/out_ready_i sample_out_o, last_out_o
//
// One item at a time: a sample is taken and evaluated, then each zeroed ring entry
// (0..64) is written in turn, then each released sample is read through the single
// ring read port and loaded, held back while the output is full and out_ready_i is low.
// Reset is asynchronous; thresholds return to 33/32/32, ring entries are not cleared.
// The output register holds the last result while the next input is taken.
module audio_silence_fragment_gate_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [asfg_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [asfg_pkg::ThrW-1:0]           cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [asfg_pkg::DataW-1:0]   sample_in_i,
  input  logic                                last_in_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [asfg_pkg::DataW-1:0]   sample_out_o,
  output logic                                last_out_o
);

  asfg_pkg::cfg_t     cfg_q, cfg_d;
  asfg_pkg::mem_req_t mem;

  logic                       out_load, out_last;
  logic [asfg_pkg::DataW-1:0] rdata;
  logic                       out_valid_q, out_valid_d;
  logic [asfg_pkg::DataW-1:0] out_sample_q, out_sample_d;
  logic                       out_last_q, out_last_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (asfg_pkg::cfg_idx_e'(cfg_idx_i))
        asfg_pkg::CfgThreshold: cfg_d.thr      = cfg_data_i;
        asfg_pkg::CfgMinRun:    cfg_d.min_run  = cfg_data_i[asfg_pkg::LenW-1:0];
        asfg_pkg::CfgMinFrag:   cfg_d.min_frag = cfg_data_i[asfg_pkg::LenW-1:0];
        default:                cfg_d          = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.thr      <= asfg_pkg::ThrReset;
      cfg_q.min_run  <= asfg_pkg::MinRunReset;
      cfg_q.min_frag <= asfg_pkg::MinFragReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  asfg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .sample_i   (sample_in_i),
    .last_i     (last_in_i),
    .out_free_i (!out_valid_q || out_ready_i),
    .in_ready_o (in_ready_o),
    .mem_o      (mem),
    .out_load_o (out_load),
    .out_last_o (out_last)
  );

  asfg_ram #(
    .Width (asfg_pkg::DataW),
    .Depth (asfg_pkg::DelayDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem.we),
    .waddr_i (mem.waddr),
    .wdata_i (mem.wdata),
    .re_i    (mem.re),
    .raddr_i (mem.raddr),
    .rdata_o (rdata)
  );

  // output register; a load only follows a read issued while it was free
  always_comb begin
    out_valid_d  = out_valid_q;
    out_sample_d = out_sample_q;
    out_last_d   = out_last_q;
    if (out_load) begin
      out_valid_d  = 1'b1;
      out_sample_d = rdata;
      out_last_d   = out_last;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_sample_q <= out_sample_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_sample_q;
  assign last_out_o   = out_last_q;

endmodule

// ----- rtl/asfg_chk.sv -----
module asfg_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              cfg_we_i,
  input logic [asfg_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input logic [asfg_pkg::ThrW-1:0]         cfg_data_i,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic signed [asfg_pkg::DataW-1:0] sample_in_i,
  input logic                              last_in_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [asfg_pkg::DataW-1:0] sample_out_o,
  input logic                              last_out_o
);

  // a stalled result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sample_out_o)
                                    && $stable(last_out_o))
    else $error("output changed while stalled");

  // each input transfer occupies the sequencer for at least the next cycle
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken in two successive cycles");

  // a result needs a ring read and a load, so transfers never come back to back
  a_out_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=> !(out_valid_o && out_ready_i))
    else $error("output transfers in two successive cycles");

endmodule

bind audio_silence_fragment_gate_core asfg_chk u_asfg_chk (.*);

// ----- tb/audio_silence_fragment_gate_core_tb.sv -----
`timescale 1ns / 1ps

module audio_silence_fragment_gate_core_tb;

  localparam int BusyWait      = 250;   // worst item: take and evaluate, 64 clears, then a read and a load per release
  localparam int HoldOffCycles = 400;
  localparam int MaxReports    = 10;
  localparam int RandItems     = 330;
  localparam logic [asfg_pkg::CfgIdxW-1:0] CfgSpare = 2'd3;

  typedef struct packed {
    logic [asfg_pkg::DataW-1:0] smp;
    logic                       lst;
  } gate_res_t;

  typedef enum logic {RowItem, RowReg} row_kind_e;

  typedef struct packed {
    row_kind_e                    kind;
    logic [asfg_pkg::CfgIdxW-1:0] reg_idx;
    logic [asfg_pkg::ThrW-1:0]    reg_val;
    logic [asfg_pkg::DataW-1:0]   smp;
    int                           rep;
    logic                         lst;
    bit                           typed;
    logic [asfg_pkg::DataW-1:0]   typed_smp;
  } stim_row_t;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              cfg_we_i;
  logic [asfg_pkg::CfgIdxW-1:0]      cfg_idx_i;
  logic [asfg_pkg::ThrW-1:0]         cfg_data_i;
  logic                              in_valid_i;
  logic                              in_ready_o;
  logic signed [asfg_pkg::DataW-1:0] sample_in_i;
  logic                              last_in_i;
  logic                              out_valid_o;
  logic                              out_ready_i;
  logic signed [asfg_pkg::DataW-1:0] sample_out_o;
  logic                              last_out_o;

  audio_silence_fragment_gate_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_in_i (sample_in_i),
    .last_in_i   (last_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sample_out_o(sample_out_o),
    .last_out_o  (last_out_o)
  );

  // gate predictor state
  logic [asfg_pkg::DataW-1:0] ring_copy [asfg_pkg::DelayDepth];
  logic [asfg_pkg::AddrW-1:0] hold_head;
  logic [asfg_pkg::CntW-1:0]  hold_fill;
  logic [asfg_pkg::RunW-1:0]  quiet_run;
  logic [asfg_pkg::RunW-1:0]  sound_len;
  asfg_pkg::cfg_t             gate_cfg;

  gate_res_t fresh_q[$];
  gate_res_t gated_q[$];
  stim_row_t dir_rows[$];

  int errors;
  int items_sent;
  int burst_left;
  int hold_left;
  bit hold_req;
  bit dirty;
  bit clip_open;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("** audio_silence_fragment_gate_core: FAILED **");
    $finish;
  end

  function automatic int ring_at(int k);
    return (int'(hold_head) + k) % asfg_pkg::DelayDepth;
  endfunction

  function automatic void zero_held(int from, int to);
    for (int k = from; k < to; k++) ring_copy[ring_at(k)] = '0;
  endfunction

  // zero the newest run_len held samples, then a short fragment ahead of them
  function automatic void clear_run(int run_len, int frag_len);
    int fill, n, rest, m;
    fill = int'(hold_fill);
    n    = (run_len < fill) ? run_len : fill;
    rest = fill - n;
    zero_held(rest, fill);
    if (frag_len > 0 && frag_len < int'(gate_cfg.min_frag)) begin
      m = (frag_len < rest) ? frag_len : rest;
      zero_held(rest - m, rest);
    end
  endfunction

  function automatic logic [asfg_pkg::RunW-1:0] sat_run(int s);
    return (s > int'(asfg_pkg::RunSat)) ? asfg_pkg::RunSat : asfg_pkg::RunW'(s);
  endfunction

  function automatic void release_oldest(logic lst);
    gate_res_t res;
    res.smp = ring_copy[hold_head];
    res.lst = lst;
    fresh_q.insert(fresh_q.size(), res);
    hold_head = asfg_pkg::AddrW'(ring_at(1));
    hold_fill = hold_fill - 1'b1;
  endfunction

  function automatic void gate_sample(logic [asfg_pkg::DataW-1:0] raw, logic lst);
    int mag, prev_run, pend;
    mag = raw[asfg_pkg::DataW-1] ? 65536 - int'(raw) : int'(raw);
    ring_copy[ring_at(int'(hold_fill))] = raw;
    hold_fill = hold_fill + 1'b1;
    if (mag < int'(gate_cfg.thr)) begin
      prev_run  = int'(quiet_run);
      quiet_run = sat_run(int'(quiet_run) + 1);
      if (quiet_run > gate_cfg.min_run) begin
        if (prev_run <= int'(gate_cfg.min_run)) clear_run(int'(quiet_run), int'(sound_len));
        else ring_copy[ring_at(int'(hold_fill) - 1)] = '0;
      end
    end else begin
      if (quiet_run > gate_cfg.min_run) sound_len = 1;
      else sound_len = sat_run(int'(sound_len) + int'(quiet_run) + 1);
      quiet_run = '0;
    end
    if (lst) begin
      if (quiet_run > 0 && quiet_run <= gate_cfg.min_run)
        clear_run(int'(quiet_run), int'(sound_len));
      while (hold_fill > 0) release_oldest(hold_fill == 1);
      hold_head = '0;
      quiet_run = '0;
      sound_len = '0;
    end else begin
      pend = 0;
      if (quiet_run <= gate_cfg.min_run) begin
        pend = int'(quiet_run);
        if (sound_len < gate_cfg.min_frag) pend += int'(sound_len);
      end
      while (hold_fill > 0 && (int'(hold_fill) > pend
                               || int'(hold_fill) >= asfg_pkg::HoldCap))
        release_oldest(1'b0);
    end
  endfunction

  function automatic stim_row_t item_row(logic [asfg_pkg::DataW-1:0] smp, int rep,
                                         logic lst);
    stim_row_t r;
    r      = '0;
    r.kind = RowItem;
    r.smp  = smp;
    r.rep  = rep;
    r.lst  = lst;
    return r;
  endfunction

  function automatic stim_row_t typed_row(logic [asfg_pkg::DataW-1:0] smp,
                                          logic [asfg_pkg::DataW-1:0] exp_smp);
    stim_row_t r;
    r           = item_row(smp, 1, 1'b1);
    r.typed     = 1'b1;
    r.typed_smp = exp_smp;
    return r;
  endfunction

  function automatic stim_row_t reg_row(logic [asfg_pkg::CfgIdxW-1:0] idx,
                                        logic [asfg_pkg::ThrW-1:0] val);
    stim_row_t r;
    r         = '0;
    r.kind    = RowReg;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic logic [asfg_pkg::LenW-1:0] pick_len();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return asfg_pkg::LenW'(32);
      2: return asfg_pkg::LenW'(63);
      default: return asfg_pkg::LenW'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic logic [asfg_pkg::DataW-1:0] quiet_value();
    int m;
    if (gate_cfg.thr == 0) return '0;
    m = $urandom_range(int'(gate_cfg.thr) - 1, 0);
    return ($urandom_range(0, 1) != 0) ? asfg_pkg::DataW'(-m) : asfg_pkg::DataW'(m);
  endfunction

  function automatic logic [asfg_pkg::DataW-1:0] loud_value();
    int m;
    if ($urandom_range(0, 1) != 0) m = $urandom_range(32768, int'(gate_cfg.thr));
    else m = int'(gate_cfg.thr) + int'($urandom_range(0, 3));
    if (m >= 32768) return 16'h8000;
    return ($urandom_range(0, 1) != 0) ? asfg_pkg::DataW'(-m) : asfg_pkg::DataW'(m);
  endfunction

  task automatic write_reg(input logic [asfg_pkg::CfgIdxW-1:0] idx,
                           input logic [asfg_pkg::ThrW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    case (idx)
      asfg_pkg::CfgThreshold: gate_cfg.thr      = val;
      asfg_pkg::CfgMinRun:    gate_cfg.min_run  = val[asfg_pkg::LenW-1:0];
      asfg_pkg::CfgMinFrag:   gate_cfg.min_frag = val[asfg_pkg::LenW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // let every expected sample out, then give the core time to go idle
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (gated_q.size() != 0) @(posedge clk_i);
    if (dirty) repeat (BusyWait) @(posedge clk_i);
    dirty = 1'b0;
  endtask

  task automatic send_item(input logic [asfg_pkg::DataW-1:0] smp, input logic lst,
                           input bit typed, input logic [asfg_pkg::DataW-1:0] typed_smp);
    gate_res_t res;
    @(negedge clk_i);
    if (burst_left == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
    end
    in_valid_i  = 1'b1;
    sample_in_i = smp;
    last_in_i   = lst;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
    items_sent++;
    dirty     = 1'b1;
    clip_open = !lst;
    fresh_q.delete();
    gate_sample(smp, lst);
    if (typed) begin
      res.smp = typed_smp;
      res.lst = 1'b1;
      gated_q.insert(gated_q.size(), res);
    end else begin
      foreach (fresh_q[i]) gated_q.insert(gated_q.size(), fresh_q[i]);
    end
  endtask

  // sound stretches and silent runs sized around the current thresholds
  task automatic send_clip();
    logic [asfg_pkg::DataW-1:0] clip_q[$];
    int run_hi, frag_hi, len;
    run_hi  = int'(gate_cfg.min_run) + 3;
    frag_hi = int'(gate_cfg.min_frag) + 2;
    if (run_hi > 70) run_hi = 70;
    if (frag_hi > 40) frag_hi = 40;
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, run_hi)) clip_q.insert(clip_q.size(), quiet_value());
    repeat ($urandom_range(1, 3)) begin
      len = $urandom_range(1, frag_hi);
      repeat (len) clip_q.insert(clip_q.size(), loud_value());
      if ($urandom_range(0, 1) != 0) len = $urandom_range(0, run_hi);
      else len = int'(gate_cfg.min_run) - 1 + int'($urandom_range(0, 2));
      if (len < 0) len = 0;
      repeat (len) clip_q.insert(clip_q.size(), quiet_value());
    end
    foreach (clip_q[i]) send_item(clip_q[i], i == clip_q.size() - 1, 1'b0, '0);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 10))
      send_item(asfg_pkg::DataW'($urandom), $urandom_range(0, 7) == 0, 1'b0, '0);
  endtask

  initial begin : receiver
    int mode, mode_left;
    gate_res_t want;
    mode        = 0;
    mode_left   = 0;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (gated_q.size() == 0) begin
          errors++;
          if (errors <= MaxReports)
            $display("unexpected transfer: sample %0d last %0b", sample_out_o, last_out_o);
        end else begin
          want = gated_q.pop_front();
          if (want.smp !== sample_out_o || want.lst !== last_out_o) begin
            errors++;
            if (errors <= MaxReports)
              $display("mismatch: expected sample %0d last %0b, got sample %0d last %0b",
                       $signed(want.smp), want.lst, sample_out_o, last_out_o);
          end
        end
      end
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i = 1'b0;
      end else if (hold_req) begin
        hold_req    = 1'b0;
        hold_left   = HoldOffCycles - 1;
        out_ready_i = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (mode)
          0: out_ready_i = 1'b1;
          1: out_ready_i = 1'($urandom_range(0, 1));
          2: out_ready_i = ($urandom_range(0, 3) == 0);
          default: out_ready_i = (mode_left % 5) < 2;
        endcase
      end
    end
  end

  initial begin : stimulus
    int phase, rand_start, phase_end;
    bit paused;
    logic [asfg_pkg::ThrW-1:0] val;

    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = asfg_pkg::CfgThreshold;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    sample_in_i = '0;
    last_in_i   = 1'b0;
    errors      = 0;
    items_sent  = 0;
    burst_left  = 0;
    hold_req    = 1'b0;
    dirty       = 1'b0;
    clip_open   = 1'b0;
    paused      = 1'b0;
    foreach (ring_copy[i]) ring_copy[i] = '0;
    hold_head = '0;
    hold_fill = '0;
    quiet_run = '0;
    sound_len = '0;
    gate_cfg  = '{thr: asfg_pkg::ThrReset, min_run: asfg_pkg::MinRunReset,
                  min_frag: asfg_pkg::MinFragReset};

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // one-sample clips under the reset thresholds
    dir_rows.insert(dir_rows.size(), typed_row(32767, 32767));
    dir_rows.insert(dir_rows.size(), typed_row(-32768, -32768));
    dir_rows.insert(dir_rows.size(), typed_row(0, 0));
    dir_rows.insert(dir_rows.size(), typed_row(-32, 0));
    dir_rows.insert(dir_rows.size(), typed_row(32, 0));
    dir_rows.insert(dir_rows.size(), typed_row(33, 33));
    dir_rows.insert(dir_rows.size(), typed_row(-33, -33));
    // fragment ahead of a long run, run still open past the limit, trailing silence
    dir_rows.insert(dir_rows.size(), reg_row(asfg_pkg::CfgMinRun, 2));
    dir_rows.insert(dir_rows.size(), reg_row(asfg_pkg::CfgMinFrag, 3));
    dir_rows.insert(dir_rows.size(), item_row(1000, 2, 1'b0));
    dir_rows.insert(dir_rows.size(), item_row(0, 4, 1'b0));
    dir_rows.insert(dir_rows.size(), item_row(-1000, 1, 1'b0));
    dir_rows.insert(dir_rows.size(), item_row(5, 1, 1'b1));
    // silent run at the very start of a clip
    dir_rows.insert(dir_rows.size(), item_row(0, 3, 1'b0));
    dir_rows.insert(dir_rows.size(), item_row(700, 1, 1'b1));
    // threshold extremes
    dir_rows.insert(dir_rows.size(), reg_row(asfg_pkg::CfgThreshold, 0));
    dir_rows.insert(dir_rows.size(), item_row(0, 1, 1'b1));
    dir_rows.insert(dir_rows.size(), reg_row(asfg_pkg::CfgThreshold, 32767));
    dir_rows.insert(dir_rows.size(), item_row(32766, 1, 1'b0));
    dir_rows.insert(dir_rows.size(), item_row(-32768, 1, 1'b1));
    // no fragment is ever short enough with a zero length
    dir_rows.insert(dir_rows.size(), reg_row(asfg_pkg::CfgThreshold, 33));
    dir_rows.insert(dir_rows.size(), reg_row(asfg_pkg::CfgMinFrag, 0));
    dir_rows.insert(dir_rows.size(), item_row(100, 1, 1'b0));
    dir_rows.insert(dir_rows.size(), item_row(0, 3, 1'b0));
    dir_rows.insert(dir_rows.size(), item_row(100, 1, 1'b1));

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == RowReg) begin
        settle();
        write_reg(dir_rows[r].reg_idx, dir_rows[r].reg_val);
      end else begin
        for (int k = 0; k < dir_rows[r].rep; k++)
          send_item(dir_rows[r].smp, dir_rows[r].lst && (k == dir_rows[r].rep - 1),
                    dir_rows[r].typed, dir_rows[r].typed_smp);
      end
    end

    rand_start = items_sent;
    phase      = 0;
    while (items_sent - rand_start < RandItems) begin
      settle();
      case ($urandom_range(0, 5))
        0: val = '0;
        1: val = asfg_pkg::ThrW'(32767);
        2: val = asfg_pkg::ThrReset;
        3, 4: val = asfg_pkg::ThrW'($urandom_range(1, 300));
        default: val = asfg_pkg::ThrW'($urandom);
      endcase
      write_reg(asfg_pkg::CfgThreshold, val);
      val = asfg_pkg::ThrW'(pick_len());
      if ($urandom_range(0, 3) == 0)
        val[asfg_pkg::ThrW-1:asfg_pkg::LenW] = (asfg_pkg::ThrW - asfg_pkg::LenW)'($urandom);
      write_reg(asfg_pkg::CfgMinRun, val);
      val = asfg_pkg::ThrW'(pick_len());
      if ($urandom_range(0, 3) == 0)
        val[asfg_pkg::ThrW-1:asfg_pkg::LenW] = (asfg_pkg::ThrW - asfg_pkg::LenW)'($urandom);
      write_reg(asfg_pkg::CfgMinFrag, val);
      if (phase % 3 == 0) write_reg(CfgSpare, asfg_pkg::ThrW'($urandom));
      // receiver backs off for a long stretch while items keep coming
      if (phase == 1) hold_req = 1'b1;
      phase_end = items_sent + $urandom_range(25, 45);
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 4) == 0) send_noise();
        else send_clip();
        if (phase == 3 && !paused) begin
          settle();
          paused = 1'b1;
        end
      end
      phase++;
    end
    if (clip_open) send_item(asfg_pkg::DataW'($urandom), 1'b1, 1'b0, '0);

    settle();
    if (errors == 0) begin
      $display("** audio_silence_fragment_gate_core: PASSED **");
    end else begin
      $display("** audio_silence_fragment_gate_core: FAILED **");
    end
    $finish;
  end

endmodule

// ----- audio_silence_fragment_gate_core.f -----
rtl/asfg_pkg.sv
rtl/asfg_ram.sv
rtl/asfg_ctrl.sv
rtl/audio_silence_fragment_gate_core.sv
rtl/asfg_chk.sv
tb/audio_silence_fragment_gate_core_tb.sv
